// ===== sv/uv_sphere_index_generator_unit_defines.svh =====
// Assertion macros shared by the sphere index generator RTL.
`ifndef UV_SPHERE_INDEX_GENERATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_INDEX_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uvs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uvs assertion failed");

`endif

// ===== sv/uvs_pkg.sv =====
// Constants and codes for the UV sphere index generator.
package uvs_pkg;

    localparam int INDEX_WIDTH = 16;
    localparam int VERTEX_WIDTH = 16;
    localparam int TRI_WIDTH = 17;
    localparam int COUNT_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PHASE_WIDTH = 2;

    localparam logic [PHASE_WIDTH-1:0] PH_TOP = 2'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_MID_A = 2'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_MID_B = 2'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_BOT = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLICE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STACK_COUNT = 2'd1;

    localparam logic [COUNT_WIDTH-1:0] SLICE_MIN = 8'd3;
    localparam logic [COUNT_WIDTH-1:0] STACK_MIN = 8'd2;
    localparam logic [COUNT_WIDTH-1:0] SLICE_RESET = 8'd8;
    localparam logic [COUNT_WIDTH-1:0] STACK_RESET = 8'd8;

endpackage

// ===== sv/uv_sphere_index_generator_unit.sv =====
// UV sphere index generator: emits one triangle of the sphere mesh per accepted word.
//
// Input channel: i_in_valid / o_in_stall carries one word with i_restart. Each
// accepted word produces exactly one triangle; i_restart high makes it triangle 0.
// Output channel: o_out_valid / i_out_stall carries the three vertex indices,
// the triangle number and a flag on the final triangle of the sphere.
// The output is registered: the triangle for an accepted word is on the output
// in the next cycle. Throughput is one triangle per cycle unless the receiver stalls;
// the state update (counters plus a few 16-bit adders) closes in the same cycle.
// When the receiver stalls, the output register holds its word and o_in_stall
// rises only while that register is full, so a word is taken in the same cycle
// the previous one leaves.
// Configuration: i_cfg_valid / o_cfg_ready, index 0 is slice_count (3..255),
// index 1 is stack_count (2..255); low values are clamped up. A write to either
// index also returns the sequence to triangle 0. Other indices are ignored.
// Reset (synchronous, active low) sets both counts to 8, restarts the sequence
// and empties the output register.
`include "uv_sphere_index_generator_unit_defines.svh"

module uv_sphere_index_generator_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_restart,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [uvs_pkg::VERTEX_WIDTH-1:0]       o_vertex_a,
    output logic [uvs_pkg::VERTEX_WIDTH-1:0]       o_vertex_b,
    output logic [uvs_pkg::VERTEX_WIDTH-1:0]       o_vertex_c,
    output logic [uvs_pkg::TRI_WIDTH-1:0]          o_triangle_number,
    output logic                                   o_last_triangle,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [uvs_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [uvs_pkg::COUNT_WIDTH-1:0]        i_cfg_data
);

    localparam int IW = uvs_pkg::INDEX_WIDTH;
    localparam int CW = uvs_pkg::COUNT_WIDTH;
    localparam int PW = uvs_pkg::PHASE_WIDTH;
    localparam int TW = uvs_pkg::TRI_WIDTH;
    localparam int VW = uvs_pkg::VERTEX_WIDTH;

    // Configuration
    logic [CW-1:0] r_slice_cnt;
    logic [CW-1:0] r_stack_cnt;

    // Sequence state
    logic [PW-1:0] r_phase, n_phase;
    logic [CW-1:0] r_slice_pos, n_slice_pos;
    logic [CW-1:0] r_band_pos, n_band_pos;
    logic [IW-1:0] r_ring_base, n_ring_base;
    logic [TW-1:0] r_tri_cnt, n_tri_cnt;

    // Output register
    logic          r_out_valid;
    logic [IW-1:0] r_vtx_a, n_vtx_a;
    logic [IW-1:0] r_vtx_b, n_vtx_b;
    logic [IW-1:0] r_vtx_c, n_vtx_c;
    logic [TW-1:0] r_tri_num;
    logic          r_last, n_last;

    logic          in_fire;
    logic          cfg_fire;
    logic [PW-1:0] cur_phase;
    logic [CW-1:0] cur_slice;
    logic [CW-1:0] cur_band;
    logic [IW-1:0] cur_base;
    logic [TW-1:0] cur_tri;
    logic          at_end;
    logic [IW-1:0] slice_ext;
    logic [IW-1:0] count_ext;
    logic [IW-1:0] base_s;
    logic [IW-1:0] base_s_up;
    logic [IW-1:0] wrap_next;
    logic [IW-1:0] base_dn;
    logic [IW-1:0] base_dn_s;
    logic [CW-1:0] band_inc;
    logic          band_done;
    logic [2*CW-1:0] pole_prod;
    logic [IW-1:0] pole;
    logic [CW-1:0] cfg_clamped_slice;
    logic [CW-1:0] cfg_clamped_stack;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_fire     = i_in_valid & ~o_in_stall;

    // A restart word is computed from the reset values of the sequence state.
    assign cur_phase = i_restart ? uvs_pkg::PH_TOP : r_phase;
    assign cur_slice = i_restart ? '0 : r_slice_pos;
    assign cur_band  = i_restart ? '0 : r_band_pos;
    assign cur_base  = i_restart ? IW'(1) : r_ring_base;
    assign cur_tri   = i_restart ? '0 : r_tri_cnt;

    assign at_end    = (cur_slice == (r_slice_cnt - CW'(1)));
    assign slice_ext = IW'(cur_slice);
    assign count_ext = IW'(r_slice_cnt);
    assign base_s    = cur_base + slice_ext;
    assign base_s_up = base_s + count_ext;
    assign wrap_next = at_end ? cur_base : (base_s + IW'(1));
    assign base_dn   = cur_base - count_ext;
    assign base_dn_s = base_dn + slice_ext;

    assign band_inc  = cur_band + CW'(1);
    assign band_done = (band_inc >= (r_stack_cnt - CW'(2)));

    // Bottom pole vertex: 1 + (stack_count - 1) * slice_count.
    assign pole_prod = (2*CW)'(r_stack_cnt - CW'(1)) * (2*CW)'(r_slice_cnt);
    assign pole      = IW'(pole_prod) + IW'(1);

    always_comb begin
        n_last = 1'b0;
        case (cur_phase)
            uvs_pkg::PH_TOP: begin
                n_vtx_a = '0;
                n_vtx_b = slice_ext + IW'(1);
                n_vtx_c = at_end ? IW'(1) : (slice_ext + IW'(2));
            end
            uvs_pkg::PH_MID_A: begin
                n_vtx_a = base_s;
                n_vtx_b = base_s_up;
                n_vtx_c = wrap_next;
            end
            uvs_pkg::PH_MID_B: begin
                n_vtx_a = wrap_next;
                n_vtx_b = base_s_up;
                n_vtx_c = wrap_next + count_ext;
            end
            default: begin
                n_vtx_a = cur_base;
                n_vtx_b = base_dn_s;
                n_vtx_c = at_end ? base_dn : (base_dn_s + IW'(1));
                n_last  = at_end;
            end
        endcase
    end

    always_comb begin
        n_tri_cnt   = cur_tri + TW'(1);
        n_phase     = cur_phase;
        n_slice_pos = cur_slice;
        n_band_pos  = cur_band;
        n_ring_base = cur_base;
        case (cur_phase)
            uvs_pkg::PH_TOP: begin
                if (at_end) begin
                    n_slice_pos = '0;
                    n_band_pos  = '0;
                    if (r_stack_cnt > CW'(2)) begin
                        n_phase     = uvs_pkg::PH_MID_A;
                        n_ring_base = IW'(1);
                    end else begin
                        n_phase     = uvs_pkg::PH_BOT;
                        n_ring_base = pole;
                    end
                end else begin
                    n_slice_pos = cur_slice + CW'(1);
                end
            end
            uvs_pkg::PH_MID_A: begin
                n_phase = uvs_pkg::PH_MID_B;
            end
            uvs_pkg::PH_MID_B: begin
                if (at_end) begin
                    n_slice_pos = '0;
                    n_band_pos  = band_inc;
                    if (band_done) begin
                        n_phase     = uvs_pkg::PH_BOT;
                        n_ring_base = pole;
                    end else begin
                        n_phase     = uvs_pkg::PH_MID_A;
                        n_ring_base = cur_base + count_ext;
                    end
                end else begin
                    n_phase     = uvs_pkg::PH_MID_A;
                    n_slice_pos = cur_slice + CW'(1);
                end
            end
            default: begin
                if (at_end) begin
                    n_phase     = uvs_pkg::PH_TOP;
                    n_slice_pos = '0;
                    n_band_pos  = '0;
                    n_ring_base = IW'(1);
                    n_tri_cnt   = '0;
                end else begin
                    n_slice_pos = cur_slice + CW'(1);
                end
            end
        endcase
    end

    assign cfg_clamped_slice = (i_cfg_data < uvs_pkg::SLICE_MIN) ? uvs_pkg::SLICE_MIN
                                                                 : i_cfg_data;
    assign cfg_clamped_stack = (i_cfg_data < uvs_pkg::STACK_MIN) ? uvs_pkg::STACK_MIN
                                                                 : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_cnt <= uvs_pkg::SLICE_RESET;
            r_stack_cnt <= uvs_pkg::STACK_RESET;
            r_phase     <= uvs_pkg::PH_TOP;
            r_slice_pos <= '0;
            r_band_pos  <= '0;
            r_ring_base <= IW'(1);
            r_tri_cnt   <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                uvs_pkg::CFG_SLICE_COUNT: begin
                    r_slice_cnt <= cfg_clamped_slice;
                    r_phase     <= uvs_pkg::PH_TOP;
                    r_slice_pos <= '0;
                    r_band_pos  <= '0;
                    r_ring_base <= IW'(1);
                    r_tri_cnt   <= '0;
                end
                uvs_pkg::CFG_STACK_COUNT: begin
                    r_stack_cnt <= cfg_clamped_stack;
                    r_phase     <= uvs_pkg::PH_TOP;
                    r_slice_pos <= '0;
                    r_band_pos  <= '0;
                    r_ring_base <= IW'(1);
                    r_tri_cnt   <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_slice_pos <= n_slice_pos;
            r_band_pos  <= n_band_pos;
            r_ring_base <= n_ring_base;
            r_tri_cnt   <= n_tri_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_vtx_a   <= n_vtx_a;
            r_vtx_b   <= n_vtx_b;
            r_vtx_c   <= n_vtx_c;
            r_tri_num <= cur_tri;
            r_last    <= n_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_vertex_a        = r_vtx_a[VW-1:0];
    assign o_vertex_b        = r_vtx_b[VW-1:0];
    assign o_vertex_c        = r_vtx_c[VW-1:0];
    assign o_triangle_number = r_tri_num;
    assign o_last_triangle   = r_last;

    `UVS_ASSERT_NEXT(a_last_wraps, i_clk, i_rst_n, in_fire && !cfg_fire && n_last, (r_phase == uvs_pkg::PH_TOP) && (r_tri_cnt == '0))
    `UVS_ASSERT_NEXT(a_cfg_restarts, i_clk, i_rst_n, cfg_fire && ((i_cfg_index == uvs_pkg::CFG_SLICE_COUNT) || (i_cfg_index == uvs_pkg::CFG_STACK_COUNT)), (r_phase == uvs_pkg::PH_TOP) && (r_tri_cnt == '0))
    `UVS_ASSERT_NOW(a_slice_in_ring, i_clk, i_rst_n, 1'b1, r_slice_pos < r_slice_cnt)
    `UVS_ASSERT_NOW(a_bands_need_stacks, i_clk, i_rst_n, (r_phase == uvs_pkg::PH_MID_A) || (r_phase == uvs_pkg::PH_MID_B), r_stack_cnt > CW'(2))

endmodule
